@@ hdl/wtg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wtg_pkg;
  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX2 = 64'h94d049bb133111eb;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLORS = 2'd2;
  localparam logic [1:0] REG_SEED   = 2'd3;

  // draw purpose codes
  typedef enum logic [2:0] {
    DR_WEST, DR_SOUTH, DR_NORTH, DR_EAST, DR_SEED
  } draw_sel_t;

  typedef struct packed {
    logic      start;     // begin a tile
    logic      restart;   // load seed and latched sizes
    logic      draw_go;   // run one generator draw
    draw_sel_t draw_sel;
    logic      use_prev;  // take west from previous east
    logic      use_line;  // take south from line store
    logic      line_rd;   // read line store at current column
    logic      finish;    // commit tile, load output register
    logic      idle_out;  // load an invalid result
  } wtg_cmd_t;

  typedef struct packed {
    logic draw_done;
    logic done_flag;
    logic first_col;
    logic first_row;
  } wtg_sts_t;
endpackage
`default_nettype wire

@@ hdl/wtg_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wtg_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 65536,
  parameter int COLOR_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_idx,
  input  wire logic [63:0]          cfg_data,
  input  wire wtg_pkg::wtg_cmd_t    cmd,
  output wtg_pkg::wtg_sts_t         sts,
  output logic                      o_valid,
  output logic [9:0]                o_x,
  output logic [15:0]               o_y,
  output logic [7:0]                o_w,
  output logic [7:0]                o_s,
  output logic [7:0]                o_n,
  output logic [7:0]                o_e,
  output logic [63:0]               o_seed,
  output logic                      o_last
);
  import wtg_pkg::*;

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int NCOL = 1 << COLOR_BITS;
  localparam int CW = COLOR_BITS + 1;

  logic [10:0] reg_width;
  logic [16:0] reg_height;
  logic [8:0]  reg_colors;
  logic [63:0] reg_seed;

  logic [10:0] act_width;
  logic [16:0] act_height;
  logic [CW-1:0] act_colors;
  logic [63:0] prng_state;
  logic [COLOR_BITS-1:0] prev_east;
  logic [9:0]  col_count;
  logic [15:0] row_count;
  logic        grid_done;

  logic [COLOR_BITS-1:0] north_line [MAX_WIDTH];
  logic [COLOR_BITS-1:0] line_q;

  // draw unit: add, xor-shift, multiply, xor-shift, multiply (both in 16-bit slices),
  // xor-shift; mod by shift-subtract
  typedef enum logic [2:0] {D_IDLE, D_MUL, D_FIN, D_MOD} dstate_t;
  dstate_t dstate;
  logic [63:0] dv;
  logic [63:0] rem;
  logic [6:0]  mbit;
  logic        ddone;
  logic [COLOR_BITS-1:0] w_c, s_c, n_c, e_c;
  logic [63:0] seed_v;
  draw_sel_t   sel;

  logic [63:0] ma;
  logic [63:0] mb;
  logic [63:0] acc;
  logic [1:0]  mcnt;
  logic        mphase;
  logic [63:0] prod;
  logic [63:0] psum;

  logic [10:0] cw_clamp;
  logic [16:0] ch_clamp;
  logic [9:0]  cc_clamp;
  logic [64:0] trial;
  logic [63:0] rem_sh;

  always_comb begin
    cw_clamp = (reg_width == 11'd0) ? 11'd1 :
               ({21'd0, reg_width} > 32'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : reg_width;
    ch_clamp = (reg_height == 17'd0) ? 17'd1 :
               ({15'd0, reg_height} > 32'(MAX_HEIGHT)) ? 17'(MAX_HEIGHT) : reg_height;
    cc_clamp = (reg_colors == 9'd0) ? 10'd1 :
               ({23'd0, reg_colors} > 32'(NCOL)) ? 10'(NCOL) : {1'b0, reg_colors};
    rem_sh = {rem[62:0], dv[63]};
    trial = {1'b0, rem_sh} - {{(65-CW){1'b0}}, act_colors};
    // one 64 x 16 slice of the product per cycle, low 64 bits kept
    prod = ma * {48'd0, mb[15:0]};
    psum = acc + prod;
  end

  always_ff @(posedge clk) begin
    if (cmd.line_rd) line_q <= north_line[col_count[XW-1:0]];
    if (cmd.finish) north_line[col_count[XW-1:0]] <= n_c;
    if (rst) begin
      reg_width <= 11'd1; reg_height <= 17'd1; reg_colors <= 9'd2; reg_seed <= '0;
      act_width <= 11'd1; act_height <= 17'd1; act_colors <= CW'(2);
      prng_state <= '0; prev_east <= '0; col_count <= '0; row_count <= '0;
      grid_done <= 1'b1; dstate <= D_IDLE; o_valid <= 1'b0; o_last <= 1'b0;
      ddone <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_WIDTH:  reg_width  <= cfg_data[10:0];
          REG_HEIGHT: reg_height <= cfg_data[16:0];
          REG_COLORS: reg_colors <= cfg_data[8:0];
          REG_SEED:   reg_seed   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.restart) begin
        act_width <= cw_clamp; act_height <= ch_clamp;
        act_colors <= CW'(cc_clamp);
        prng_state <= reg_seed; col_count <= '0; row_count <= '0;
        prev_east <= '0; grid_done <= 1'b0;
      end
      if (cmd.use_prev) w_c <= prev_east;
      if (cmd.use_line) s_c <= line_q;
      case (dstate)
        D_IDLE: begin
          ddone <= 1'b0;
          if (cmd.draw_go) begin
            sel <= cmd.draw_sel;
            prng_state <= prng_state + GOLDEN;
            ma <= (prng_state + GOLDEN) ^ ((prng_state + GOLDEN) >> 30);
            mb <= MIX1;
            acc <= '0;
            mcnt <= 2'd0;
            mphase <= 1'b0;
            dstate <= D_MUL;
          end
        end
        D_MUL: begin
          mcnt <= mcnt + 2'd1;
          if (mcnt != 2'd3) begin
            ma <= {ma[47:0], 16'd0}; mb <= {16'd0, mb[63:16]}; acc <= psum;
          end else if (!mphase) begin
            // start the second multiply on the first product
            ma <= psum ^ (psum >> 27); mb <= MIX2; acc <= '0; mphase <= 1'b1;
          end else begin
            dv <= psum; dstate <= D_FIN;
          end
        end
        D_FIN: begin
          dv <= dv ^ (dv >> 31);
          if (sel == DR_SEED) begin
            seed_v <= dv ^ (dv >> 31); ddone <= 1'b1; dstate <= D_IDLE;
          end else begin
            rem <= '0; mbit <= 7'd0; dstate <= D_MOD;
          end
        end
        D_MOD: begin
          // one quotient bit per cycle, msb first
          dv <= {dv[62:0], 1'b0};
          rem <= trial[64] ? rem_sh : trial[63:0];
          mbit <= mbit + 7'd1;
          if (mbit == 7'd63) begin
            case (sel)
              DR_WEST:  w_c <= trial[64] ? rem_sh[COLOR_BITS-1:0] : trial[COLOR_BITS-1:0];
              DR_SOUTH: s_c <= trial[64] ? rem_sh[COLOR_BITS-1:0] : trial[COLOR_BITS-1:0];
              DR_NORTH: n_c <= trial[64] ? rem_sh[COLOR_BITS-1:0] : trial[COLOR_BITS-1:0];
              DR_EAST:  e_c <= trial[64] ? rem_sh[COLOR_BITS-1:0] : trial[COLOR_BITS-1:0];
              default: ;
            endcase
            ddone <= 1'b1; dstate <= D_IDLE;
          end
        end
        default: dstate <= D_IDLE;
      endcase
      if (cmd.finish) begin
        o_valid <= 1'b1;
        o_x <= col_count; o_y <= row_count;
        o_w <= 8'(w_c); o_s <= 8'(s_c); o_n <= 8'(n_c); o_e <= 8'(e_c);
        o_seed <= seed_v;
        o_last <= ({1'b0, col_count} + 11'd1 == act_width) &&
                  ({1'b0, row_count} + 17'd1 == act_height);
        prev_east <= e_c;
        if ({1'b0, col_count} + 11'd1 == act_width) begin
          col_count <= '0;
          if ({1'b0, row_count} + 17'd1 == act_height) grid_done <= 1'b1;
          else row_count <= row_count + 16'd1;
        end else begin
          col_count <= col_count + 10'd1;
        end
      end else if (cmd.idle_out) begin
        o_valid <= 1'b0; o_x <= '0; o_y <= '0; o_w <= '0; o_s <= '0;
        o_n <= '0; o_e <= '0; o_seed <= '0; o_last <= 1'b0;
      end
    end
  end

  assign sts.draw_done = ddone;
  assign sts.done_flag = grid_done;
  assign sts.first_col = (col_count == 10'd0);
  assign sts.first_row = (row_count == 16'd0);
endmodule
`default_nettype wire

@@ hdl/wtg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wtg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              restart,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire wtg_pkg::wtg_sts_t sts,
  output wtg_pkg::wtg_cmd_t      cmd
);
  import wtg_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DRAW, S_WAIT, S_OUT} state_t;
  state_t state;
  draw_sel_t step;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.restart = in_valid && in_ready && restart;
    cmd.line_rd = (state == S_CHECK);
    // no draw when south comes from the line store
    cmd.draw_go = (state == S_DRAW) && !((step == DR_SOUTH) && !sts.first_row);
    cmd.draw_sel = step;
    cmd.use_prev = (state == S_CHECK) && !sts.first_col;
    cmd.use_line = (state == S_DRAW) && (step == DR_SOUTH) && !sts.first_row;
    cmd.finish = (state == S_OUT);
    cmd.idle_out = (state == S_CHECK) && sts.done_flag;
    cmd.start = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; step <= DR_WEST;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd.start) state <= S_CHECK;
        S_CHECK: begin
          if (sts.done_flag) begin
            out_valid <= 1'b1; state <= S_IDLE;
          end else begin
            step <= sts.first_col ? DR_WEST : DR_SOUTH;
            state <= S_DRAW;
          end
        end
        S_DRAW: begin
          if (step == DR_SOUTH && !sts.first_row) step <= DR_NORTH;
          else state <= S_WAIT;
        end
        S_WAIT: if (sts.draw_done) begin
          if (step == DR_SEED) state <= S_OUT;
          else begin
            step <= draw_sel_t'(step + 3'd1);
            state <= S_DRAW;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> out_valid) else $error("result not presented");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

@@ hdl/wang_tile_grid_generator_core.sv @@
// channel | signals                              | direction
// input   | in_valid, in_ready, restart          | in
// result  | out_valid, out_ready, tile_* fields  | out
// config  | cfg_we, cfg_index, cfg_data          | in
// A colour draw runs issue, eight 16-bit multiply slices, finish, a 64-step
// restoring remainder and hand-back; the seed draw skips the remainder. In the
// grid interior only north, east and seed are drawn; the first row adds a south
// draw, the first column a west draw. An idle item shows with tile_valid low.
// Synchronous reset clears control. A held result blocks new items until taken.
`timescale 1ns / 1ps
`default_nettype none
module wang_tile_grid_generator_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 65536,
  parameter int COLOR_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             tile_valid,
  output logic [9:0]       tile_x,
  output logic [15:0]      tile_y,
  output logic [7:0]       west_color,
  output logic [7:0]       south_color,
  output logic [7:0]       north_color,
  output logic [7:0]       east_color,
  output logic [63:0]      tile_seed,
  output logic             last_tile
);
  import wtg_pkg::*;
  wtg_cmd_t cmd;
  wtg_sts_t sts;

  wtg_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .restart, .out_valid,
    .out_ready, .sts, .cmd);

  wtg_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .COLOR_BITS(COLOR_BITS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_idx(cfg_index), .cfg_data, .cmd, .sts,
    .o_valid(tile_valid), .o_x(tile_x), .o_y(tile_y), .o_w(west_color),
    .o_s(south_color), .o_n(north_color), .o_e(east_color),
    .o_seed(tile_seed), .o_last(last_tile));
endmodule
`default_nettype wire
